[hw/rtl/bld_pkg.sv]
// ----------------------------------------------------------------------------
// bld_pkg
// Shared types and constants for the byte-level text decoder.
// ----------------------------------------------------------------------------
package bld_pkg;

    // most result bytes a single item can cause
    localparam int MAX_RESULTS = 4;

    // result queue between the front and the back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // width of a result count (0 .. MAX_RESULTS)
    localparam int RCNT_W = $clog2(MAX_RESULTS + 1);
    // width of an index into the result bytes of one entry
    localparam int RIDX_W = $clog2(MAX_RESULTS);

    // all result bytes caused by one item, in output order
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [RCNT_W-1:0]           count;
    } seq_t;

endpackage

[hw/rtl/bld_front.sv]
// ----------------------------------------------------------------------------
// bld_front
// Accepts text bytes, groups them into UTF-8 sequences and works out every
// result byte that an item causes; one queue entry per item with results.
// ----------------------------------------------------------------------------
module bld_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     text_byte,
    input  logic           end_of_text,
    input  logic           q_full,
    output logic           push,
    output bld_pkg::seq_t  push_entry
);

    // byte-to-unicode map boundaries
    localparam logic [10:0] CP_LO1_MIN  = 11'h0A1;
    localparam logic [10:0] CP_LO1_MAX  = 11'h0AC;
    localparam logic [10:0] CP_LO2_MIN  = 11'h0AE;
    localparam logic [10:0] CP_LO2_MAX  = 11'h0FF;
    localparam logic [10:0] CP_SHIFT_MIN = 11'h100;
    localparam logic [10:0] CP_SHIFT_MAX = 11'h143;
    localparam logic [7:0]  N_CTRL_MAX  = 8'd32;
    localparam logic [7:0]  N_HIGH_MAX  = 8'd66;
    localparam logic [7:0]  N_HIGH_OFS  = 8'h5E;
    localparam logic [7:0]  SOFT_HYPHEN = 8'hAD;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } map_t;

    // sequence length from a lead byte, 0 for an invalid lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        priority if (b[7] == 1'b0)          len = 3'd1;
        else if (b[7:5] == 3'b110)         len = 3'd2;
        else if (b[7:4] == 4'b1110)        len = 3'd3;
        else if (b[7:3] == 5'b11110)       len = 3'd4;
        else                               len = 3'd0;
        return len;
    endfunction

    // reverse map of a two-byte code point
    function automatic map_t map_pair(input logic [7:0] s0, input logic [7:0] s1);
        logic [10:0] cp;
        logic [7:0]  n;
        map_t        m;
        cp = {s0[4:0], s1[5:0]};
        n  = cp[7:0];
        m  = '0;
        if ((cp >= CP_LO1_MIN && cp <= CP_LO1_MAX) ||
            (cp >= CP_LO2_MIN && cp <= CP_LO2_MAX))
        begin
            m.hit   = 1'b1;
            m.value = cp[7:0];
        end
        else if (cp >= CP_SHIFT_MIN && cp <= CP_SHIFT_MAX)
        begin
            m.hit = 1'b1;
            priority if (n <= N_CTRL_MAX) m.value = n;
            else if (n <= N_HIGH_MAX)     m.value = n + N_HIGH_OFS;
            else                          m.value = SOFT_HYPHEN;
        end
        return m;
    endfunction

    // results of one complete sequence of len bytes
    function automatic bld_pkg::seq_t emit_seq(input logic [3:0][7:0] s,
                                               input logic [2:0] len);
        map_t          m;
        bld_pkg::seq_t r;
        m = map_pair(s[0], s[1]);
        r = '0;
        if (len == 3'd2 && s[1][7:6] == 2'b10 && m.hit)
        begin
            r.data[0] = m.value;
            r.count   = bld_pkg::RCNT_W'(1);
        end
        else
        begin
            r.data  = s;
            r.count = bld_pkg::RCNT_W'(len);
        end
        return r;
    endfunction

    // rescan of the bytes behind a dropped lead at end of text
    function automatic bld_pkg::seq_t tail_scan(input logic [7:0] t1,
                                                input logic [7:0] t2,
                                                input logic [1:0] held);
        logic [2:0]    l1;
        logic [2:0]    l2;
        bld_pkg::seq_t r;
        l1 = lead_len(t1);
        l2 = lead_len(t2);
        r  = '0;
        if (held == 2'd2)
        begin
            if (l1 == 3'd1)
            begin
                r.data[0] = t1;
                r.count   = bld_pkg::RCNT_W'(1);
            end
        end
        else if (held == 2'd3)
        begin
            if (l1 == 3'd2)
            begin
                r = emit_seq({8'h00, 8'h00, t2, t1}, 3'd2);
            end
            else
            begin
                if (l1 == 3'd1)
                begin
                    r.data[0] = t1;
                    r.count   = bld_pkg::RCNT_W'(1);
                end
                if (l2 == 3'd1)
                begin
                    r.data[r.count[bld_pkg::RIDX_W-1:0]] = t2;
                    r.count = r.count + bld_pkg::RCNT_W'(1);
                end
            end
        end
        return r;
    endfunction

    logic [7:0]       pend_reg [3];
    logic [7:0]       pend_next [3];
    logic [2:0]       exp_reg;
    logic [2:0]       exp_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic [2:0]       len_b;
    logic [2:0]       n1;
    logic [3:0][7:0]  full_s;
    logic             accept;
    bld_pkg::seq_t    entry;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // sequence assembly and result generation
    always_comb
    begin
        len_b = lead_len(text_byte);
        n1    = {1'b0, cnt_reg} + 3'd1;

        // held bytes with the new byte appended
        full_s[0] = (cnt_reg == 2'd0) ? text_byte : pend_reg[0];
        full_s[1] = (cnt_reg > 2'd1)  ? pend_reg[1] : text_byte;
        full_s[2] = (cnt_reg > 2'd2)  ? pend_reg[2] : text_byte;
        full_s[3] = text_byte;

        pend_next = pend_reg;
        exp_next  = exp_reg;
        cnt_next  = cnt_reg;
        entry     = '0;

        if (exp_reg == 3'd0)
        begin
            if (len_b == 3'd1)
            begin
                entry.data[0] = text_byte;
                entry.count   = bld_pkg::RCNT_W'(1);
            end
            else if (len_b != 3'd0)
            begin
                pend_next[0] = text_byte;
                cnt_next     = 2'd1;
                exp_next     = len_b;
            end
        end
        else
        begin
            if (n1 >= exp_reg)
            begin
                entry    = emit_seq(full_s, n1);
                exp_next = 3'd0;
                cnt_next = 2'd0;
            end
            else
            begin
                pend_next[cnt_reg] = text_byte;
                cnt_next           = n1[1:0];
            end
        end

        // unfinished sequence at end of text: drop the lead, rescan the rest
        if (end_of_text && exp_next != 3'd0)
        begin
            entry    = tail_scan(pend_next[1], pend_next[2], cnt_next);
            exp_next = 3'd0;
            cnt_next = 2'd0;
        end
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= 3'd0;
            cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            exp_reg <= exp_next;
            cnt_reg <= cnt_next;
        end
    end

    // held bytes, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= pend_next;
        end
    end

    assign push       = accept && (entry.count != '0);
    assign push_entry = entry;

endmodule

[hw/rtl/bld_queue.sv]
// ----------------------------------------------------------------------------
// bld_queue
// Short queue of per-item result entries between the front and the back.
// ----------------------------------------------------------------------------
module bld_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bld_pkg::seq_t  push_entry,
    input  logic           pop,
    output bld_pkg::seq_t  head,
    output logic           full,
    output logic           empty
);

    bld_pkg::seq_t                 mem_reg [bld_pkg::QDEPTH];
    logic [bld_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [bld_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [bld_pkg::QCNT_W-1:0]    fill_reg;
    logic [bld_pkg::QCNT_W-1:0]    fill_next;

    assign full  = (fill_reg == bld_pkg::QCNT_W'(bld_pkg::QDEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        fill_next = fill_reg;
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + bld_pkg::QCNT_W'(1);
            2'b01:   fill_next = fill_reg - bld_pkg::QCNT_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bld_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bld_pkg::QPTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[hw/rtl/bld_back.sv]
// ----------------------------------------------------------------------------
// bld_back
// Plays out the queued entries one result byte at a time and marks the
// final byte of each item.
// ----------------------------------------------------------------------------
module bld_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  bld_pkg::seq_t  head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           last_of_run
);

    logic [bld_pkg::RIDX_W-1:0] idx_reg;
    logic [bld_pkg::RIDX_W-1:0] idx_next;
    logic                       fire;

    assign out_valid   = !empty;
    assign out_byte    = head.data[idx_reg];
    assign last_of_run = ((bld_pkg::RCNT_W'(idx_reg) + bld_pkg::RCNT_W'(1)) == head.count);
    assign fire        = out_valid && out_ready;
    assign pop         = fire && last_of_run;

    // byte index within the head entry
    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = last_of_run ? '0 : idx_reg + bld_pkg::RIDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

[hw/rtl/byte_level_unicode_to_byte_decoder.sv]
// The results of an accepted item are registered as one queue entry.
// Throughput: one item per cycle while each item causes at most one result
// and out_ready is high; a multi-result item holds the output until it is
// out; the four-entry result queue absorbs such bursts before input stalls.
// Reset: rst_n is asynchronous; it closes any open sequence and empties
// the queue. Held sequence bytes are not cleared.
// ----------------------------------------------------------------------------
// byte_level_unicode_to_byte_decoder
// Turns byte-level BPE token text back into raw bytes: front part groups
// UTF-8 sequences and maps them, back part streams out the result bytes.
// ----------------------------------------------------------------------------
module byte_level_unicode_to_byte_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic           q_full;
    logic           q_empty;
    logic           push;
    logic           pop;
    bld_pkg::seq_t  push_entry;
    bld_pkg::seq_t  head;

    // sequence assembly and mapping
    bld_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // per-item result queue
    bld_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // result byte streaming
    bld_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

[hw/rtl/bld_checker.sv]
// ----------------------------------------------------------------------------
// bld_checker
// Port-level checks on the byte-level decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bld_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       last_of_run
);

    logic [1:0] run_reg;
    logic       out_fire;
    logic       in_fire;

    assign out_fire = out_valid && out_ready;
    assign in_fire  = in_valid && in_ready;

    // result bytes delivered so far in the current item's run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 2'd0;
        end
        else if (out_fire)
        begin
            run_reg <= last_of_run ? 2'd0 : run_reg + 2'd1;
        end
    end

    // a stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(text_byte) && $stable(end_of_text))
        else $error("input item changed while stalled");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
        else $error("result item changed while stalled");

    // no result appears without an accepted input item
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !in_fire |=> !out_valid)
        else $error("result item appeared without input");

    // with nothing pending the input side is never stalled
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no results pending");

    // one item causes at most four result items
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !last_of_run |-> run_reg < 2'd3)
        else $error("run longer than four result items");

endmodule

bind byte_level_unicode_to_byte_decoder bld_checker u_bld_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte-level text decoder.
// Streams token text made mostly of well-formed UTF-8 characters (GPT-2 map
// code points and arbitrary ones), mixed with noise, broken and cut-short
// sequences. A scoreboard predicts every result byte and checks each one.
// The sender idles at random; the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------

// Holds the decoder state and the queue of result bytes still to come
class decode_scoreboard;

    localparam logic [7:0] PRINT_LO  = 8'h21;   // '!'
    localparam logic [7:0] PRINT_HI  = 8'h7E;   // '~'
    localparam int unsigned SHIFT_BASE = 256;   // shifted code points start here
    localparam int unsigned SHIFT_CTRL = 32;    // last shifted control byte
    localparam int unsigned SHIFT_HIGH = 66;    // last shifted 0x7F..0xA0 byte
    localparam int unsigned SHIFT_SHY  = 67;    // soft hyphen slot

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } result_t;

    result_t     pending_q[$];
    logic [7:0]  step_out[$];

    // copy of the sequence state
    logic [7:0]  held[3];
    logic [2:0]  want_len;
    logic [1:0]  held_cnt;

    int unsigned errors;
    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_eot;
    int unsigned n_cut;

    function new();
        want_len  = '0;
        held_cnt  = '0;
        errors    = 0;
        n_items   = 0;
        n_results = 0;
        n_eot     = 0;
        n_cut     = 0;
    endfunction

    task report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    // UTF-8 length from the lead byte, 0 for a byte that cannot lead
    function int unsigned lead_len(input logic [7:0] b);
        if (b[7] == 1'b0)
            return 1;
        if (b[7:5] == 3'b110)
            return 2;
        if (b[7:4] == 4'b1110)
            return 3;
        if (b[7:3] == 5'b11110)
            return 4;
        return 0;
    endfunction

    function void put_byte(input logic [7:0] v);
        if (step_out.size() < 4)
            step_out = {step_out, v};
    endfunction

    // one complete sequence: mapped byte if canonical and in the map, else raw
    function void emit_seq(input logic [3:0][7:0] s, input int unsigned start,
                           input int unsigned len);
        logic [10:0] cp;
        int unsigned shift;
        if (len == 1 && s[start] >= PRINT_LO && s[start] <= PRINT_HI)
        begin
            put_byte(s[start]);
            return;
        end
        if (len == 2 && s[start+1][7:6] == 2'b10)
        begin
            cp = {s[start][4:0], s[start+1][5:0]};
            if (cp >= 11'h080)
            begin
                if ((cp >= 11'h0A1 && cp <= 11'h0AC) || (cp >= 11'h0AE && cp <= 11'h0FF))
                begin
                    put_byte(cp[7:0]);
                    return;
                end
                if (cp >= SHIFT_BASE && cp <= SHIFT_BASE + SHIFT_SHY)
                begin
                    shift = cp - SHIFT_BASE;
                    if (shift <= SHIFT_CTRL)
                        put_byte(8'(shift));
                    else if (shift <= SHIFT_HIGH)
                        put_byte(8'(8'h7F + shift - (SHIFT_CTRL + 1)));
                    else
                        put_byte(8'hAD);
                    return;
                end
            end
        end
        for (int i = 0; i < len; i++)
            put_byte(s[start+i]);
    endfunction

    // rescan held bytes at end of text; incomplete leads are dropped
    function void scan_tail(input logic [3:0][7:0] s, input int unsigned n);
        int unsigned pos;
        int unsigned len;
        pos = 0;
        while (pos < n)
        begin
            len = lead_len(s[pos]);
            if (len == 0 || pos + len > n)
                pos++;
            else
            begin
                emit_seq(s, pos, len);
                pos += len;
            end
        end
    endfunction

    // accepted input item: advance the state and queue its results
    function void note_item(input logic [7:0] b, input logic eot);
        logic [3:0][7:0] seq;
        int unsigned n;
        int unsigned len;
        result_t r;
        seq = '0;
        step_out.delete();
        n_items++;
        if (eot)
            n_eot++;
        if (want_len == 0)
        begin
            len = lead_len(b);
            if (len == 1)
            begin
                seq[0] = b;
                emit_seq(seq, 0, 1);
            end
            else if (len > 1)
            begin
                held[0]  = b;
                held_cnt = 2'd1;
                want_len = 3'(len);
            end
        end
        else
        begin
            n = held_cnt;
            for (int i = 0; i < n; i++)
                seq[i] = held[i];
            seq[n] = b;
            n++;
            if (n >= want_len)
            begin
                emit_seq(seq, 0, n);
                want_len = '0;
                held_cnt = '0;
            end
            else
            begin
                held[n-1] = b;
                held_cnt  = 2'(n);
            end
        end
        // sequence left open by the end of the text
        if (eot && want_len != 0)
        begin
            n_cut++;
            n = held_cnt;
            for (int i = 0; i < n; i++)
                seq[i] = held[i];
            scan_tail(seq, n);
            want_len = '0;
            held_cnt = '0;
        end
        foreach (step_out[i])
        begin
            r.value   = step_out[i];
            r.last    = (i == step_out.size() - 1) ? 1'b1 : 1'b0;
            pending_q = {pending_q, r};
        end
    endfunction

    // accepted result item: compare with the oldest expectation
    task check_result(input logic [7:0] v, input logic last);
        result_t want;
        n_results++;
        if (pending_q.size() == 0)
        begin
            report($sformatf("unexpected result byte %02h last %0b", v, last));
            return;
        end
        want = pending_q.pop_front();
        if (v !== want.value)
            report($sformatf("out_byte %02h, predicted %02h", v, want.value));
        if (last !== want.last)
            report($sformatf("last_of_run %0b, predicted %0b (byte %02h)",
                             last, want.last, want.value));
    endtask

endclass

module tb;

    localparam int unsigned ITEM_TARGET = 330;
    localparam int unsigned LIMIT_TIME  = 2000000;
    localparam int unsigned SETTLE      = 20;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] text_byte   = 8'h00;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_run;

    decode_scoreboard sb = new();

    int unsigned burst_left = 0;
    int unsigned items_sent = 0;
    int unsigned rx_cycle   = 0;

    byte_level_unicode_to_byte_decoder i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: rotates its stall pattern: none, random and two fixed ones
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 97) % 4)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= (rx_cycle % 5 == 0);
            default: out_ready <= ((rx_cycle % 23) >= 12);
        endcase
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_byte, last_of_run);
    end

    // send one text byte; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 7);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(b, eot);
        items_sent++;
        @(negedge clk);
    endtask

    // hold the input off until every predicted result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending_q.size() != 0);
    endtask

    // canonical UTF-8 of a code point, optionally cut short by end of text
    task automatic send_char(input logic [20:0] cp, input bit cut, input bit eot_last);
        logic [3:0][7:0] enc;
        int unsigned len;
        int unsigned k;
        enc = '0;
        if (cp < 21'h80)
        begin
            enc[0] = cp[7:0];
            len = 1;
        end
        else if (cp < 21'h800)
        begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            len = 2;
        end
        else if (cp < 21'h10000)
        begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            len = 3;
        end
        else
        begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            len = 4;
        end
        k = (cut && len > 1) ? $urandom_range(1, len - 1) : len;
        for (int i = 0; i < k; i++)
            send_byte(enc[i], (i == k - 1) && (cut || eot_last));
    endtask

    // code point that the byte-to-unicode map gives a byte
    function automatic logic [20:0] map_code_point(input logic [7:0] v);
        if ((v >= 8'h21 && v <= 8'h7E) || (v >= 8'hA1 && v <= 8'hAC) || v >= 8'hAE)
            return 21'(v);
        if (v <= 8'h20)
            return 21'(256 + v);
        if (v <= 8'hA0)
            return 21'(256 + 33 + (v - 8'h7F));
        return 21'(256 + 67);
    endfunction

    // time limit
    initial
    begin
        #(LIMIT_TIME);
        $display("Mismatches found");
        $finish;
    end

    // stimulus
    initial
    begin
        int unsigned pick;
        int unsigned tail;
        bit          cut;
        bit          eot_last;
        bit          paused;
        paused = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // printable ends and a raw control byte
        send_byte(8'h21, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h00, 1'b0);
        // shifted space, soft hyphen slot, unmapped soft hyphen
        send_byte(8'hC4, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hC5, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hAD, 1'b0);
        // invalid lead dropped
        send_byte(8'hFF, 1'b0);
        // second byte is no continuation: raw pass
        send_byte(8'hC4, 1'b0);
        send_byte(8'h41, 1'b0);
        // three- and four-byte characters, the latter closing the text
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b1);
        // cut short: lead dropped, rest scanned again
        send_byte(8'hF0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC4, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hC4, 1'b0);
        send_byte(8'hA0, 1'b1);
        // end of text with nothing open
        send_byte(8'h41, 1'b1);

        // random text, mostly well-formed characters
        while (items_sent < ITEM_TARGET)
        begin
            pick     = $urandom_range(0, 99);
            cut      = ($urandom_range(0, 11) == 0);
            eot_last = ($urandom_range(0, 15) == 0);
            if (pick < 45)
                send_char(map_code_point(8'($urandom_range(0, 255))), cut, eot_last);
            else if (pick < 60)
                send_char(21'($urandom_range(32'h80, 32'h7FF)), cut, eot_last);
            else if (pick < 68)
                send_char(21'($urandom_range(32'h800, 32'hFFFF)), cut, eot_last);
            else if (pick < 73)
                send_char(21'($urandom_range(32'h10000, 32'h10FFFF)), cut, eot_last);
            else if (pick < 88)
                send_byte(8'($urandom_range(0, 255)), eot_last);
            else
            begin
                // broken sequence: any high lead, then random bytes
                send_byte(8'($urandom_range(8'hC0, 8'hFF)), 1'b0);
                tail = $urandom_range(0, 3);
                for (int i = 0; i < tail; i++)
                    send_byte(8'($urandom_range(0, 255)), eot_last && (i == tail - 1));
            end
            if (!paused && items_sent >= ITEM_TARGET / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
        end

        // wind down
        drain_results();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d text bytes (%0d ends of text, %0d sequences cut short)",
                 sb.n_items, sb.n_eot, sb.n_cut);
        $display("Checked %0d result bytes, %0d errors", sb.n_results, sb.errors);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/bld_pkg.sv
hw/rtl/bld_front.sv
hw/rtl/bld_queue.sv
hw/rtl/bld_back.sv
hw/rtl/byte_level_unicode_to_byte_decoder.sv
hw/rtl/bld_checker.sv
test/tb.sv
